/* src/tia_pkg.sv */
package tia_pkg;

  // Field widths.
  localparam int SideW  = 16;
  localparam int HalfW  = 18;
  localparam int DiffW  = 17;
  localparam int AreaW  = 27;
  localparam int InrW   = 15;

  // Arithmetic widths of the back end.
  localparam int RadW   = 54;   // radicand and dividend width
  localparam int RootW  = 27;   // square root of a RadW-bit value
  localparam int RemW   = 30;   // square root partial remainder
  localparam int DvsrW  = 20;   // divisor 4*x
  localparam int DivSteps = RadW;

  // Decoupling queue.
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;
  localparam int QueueCntW  = 3;

  typedef struct packed {
    logic             is_tri;
    logic [HalfW-1:0] x;
    logic [DiffW-1:0] p;
    logic [DiffW-1:0] q;
    logic [DiffW-1:0] r;
  } tia_item_t;

  typedef struct packed {
    logic             is_tri;
    logic [HalfW-1:0] x;
    logic [AreaW-1:0] area;
    logic [InrW-1:0]  inr;
  } tia_result_t;

  typedef struct packed {
    logic [DvsrW-1:0] rem;
    logic [RadW-1:0]  word;   // remaining dividend bits above, quotient bits below
  } div_state_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_state_t;

  // One restoring division step: one quotient bit.
  function automatic div_state_t div_step(div_state_t s, logic [DvsrW-1:0] d);
    logic [DvsrW:0] cur;
    div_state_t     n;
    cur = {s.rem, s.word[RadW-1]};
    if (cur >= {1'b0, d}) begin
      n.rem  = DvsrW'(cur - {1'b0, d});
      n.word = {s.word[RadW-2:0], 1'b1};
    end else begin
      n.rem  = cur[DvsrW-1:0];
      n.word = {s.word[RadW-2:0], 1'b0};
    end
    return n;
  endfunction

  // One digit-by-digit square root step: one root bit from two radicand bits.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    sqrt_state_t     n;
    cur   = {s.rem[RemW-3:0], s.rad[RadW-1:RadW-2]};
    trial = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      n.rem  = cur - trial;
      n.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      n.rem  = cur;
      n.root = {s.root[RootW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

/* src/tia_front.sv */
module tia_front (
  input  logic [tia_pkg::SideW-1:0] side_a_i,
  input  logic [tia_pkg::SideW-1:0] side_b_i,
  input  logic [tia_pkg::SideW-1:0] side_c_i,
  output tia_pkg::tia_item_t        item_o
);

  logic [tia_pkg::SideW:0]   sum_ab, sum_ac, sum_bc;
  logic [tia_pkg::HalfW-1:0] x, pa, pb, pc;

  always_comb begin
    sum_ab = {1'b0, side_a_i} + {1'b0, side_b_i};
    sum_ac = {1'b0, side_a_i} + {1'b0, side_c_i};
    sum_bc = {1'b0, side_b_i} + {1'b0, side_c_i};
    x      = {1'b0, sum_ab} + {2'b0, side_c_i};
    pa     = x - {1'b0, side_a_i, 1'b0};
    pb     = x - {1'b0, side_b_i, 1'b0};
    pc     = x - {1'b0, side_c_i, 1'b0};
    item_o.is_tri = (sum_ab > {1'b0, side_c_i}) && (sum_ac > {1'b0, side_b_i}) &&
                    (sum_bc > {1'b0, side_a_i});
    item_o.x = x;
    // For a real triangle each s-side term is below 2^17.
    item_o.p = pa[tia_pkg::DiffW-1:0];
    item_o.q = pb[tia_pkg::DiffW-1:0];
    item_o.r = pc[tia_pkg::DiffW-1:0];
  end

endmodule

/* src/tia_queue.sv */
module tia_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tia_pkg::tia_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_vld_o,
  output tia_pkg::tia_item_t head_o
);

  tia_pkg::tia_item_t             mem_q [0:tia_pkg::QueueDepth-1];
  logic [tia_pkg::QueueAw-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tia_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o     = (cnt_q == tia_pkg::QueueCntW'(tia_pkg::QueueDepth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && head_vld_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + tia_pkg::QueueCntW'(do_push) - tia_pkg::QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* src/tia_back.sv */
module tia_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 head_vld_i,
  input  tia_pkg::tia_item_t   head_i,
  output logic                 tail_vld_o,
  output tia_pkg::tia_result_t tail_o
);

  localparam int NDiv = tia_pkg::DivSteps;
  localparam int NSq  = tia_pkg::RootW;

  // Products stage.
  logic        s1_vld_q, s1_tri_q;
  logic [17:0] s1_x_q;
  logic [34:0] s1_m1_q;
  logic [33:0] s1_m2_q, s1_pq_q;
  logic [16:0] s1_r_q;

  // Partial products stage.
  logic        s2_vld_q, s2_tri_q;
  logic [17:0] s2_x_q;
  logic [34:0] s2_ll_q, s2_lh_q;
  logic [33:0] s2_hl_q, s2_hh_q;
  logic [50:0] s2_pqr_q;
  logic [68:0] prod;

  // Divider stages, area root running alongside.
  logic                     dv_vld_q [0:NDiv];
  logic                     dv_tri_q [0:NDiv];
  logic [17:0]              dv_x_q   [0:NDiv];
  tia_pkg::div_state_t      dv_q     [0:NDiv];
  tia_pkg::sqrt_state_t     ar_q     [0:NDiv];

  // Inradius root stages.
  logic                        in_vld_q  [0:NSq];
  logic                        in_tri_q  [0:NSq];
  logic [17:0]                 in_x_q    [0:NSq];
  logic [tia_pkg::AreaW-1:0]   in_area_q [0:NSq];
  tia_pkg::sqrt_state_t        in_q      [0:NSq];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= head_vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_tri_q <= head_i.is_tri;
      s1_x_q   <= head_i.x;
      s1_m1_q  <= {17'b0, head_i.x} * {18'b0, head_i.p};
      s1_m2_q  <= {17'b0, head_i.q} * {17'b0, head_i.r};
      s1_pq_q  <= {17'b0, head_i.p} * {17'b0, head_i.q};
      s1_r_q   <= head_i.r;
      s2_tri_q <= s1_tri_q;
      s2_x_q   <= s1_x_q;
      s2_ll_q  <= {17'b0, s1_m1_q[17:0]} * {18'b0, s1_m2_q[16:0]};
      s2_lh_q  <= {17'b0, s1_m1_q[17:0]} * {18'b0, s1_m2_q[33:17]};
      s2_hl_q  <= {17'b0, s1_m1_q[34:18]} * {17'b0, s1_m2_q[16:0]};
      s2_hh_q  <= {17'b0, s1_m1_q[34:18]} * {17'b0, s1_m2_q[33:17]};
      s2_pqr_q <= {17'b0, s1_pq_q} * {34'b0, s1_r_q};
    end
  end

  assign prod = 69'(s2_ll_q) + (69'(s2_lh_q) << 17) + (69'(s2_hl_q) << 18) +
                (69'(s2_hh_q) << 35);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_tri_q[0]    <= s2_tri_q;
      dv_x_q[0]      <= s2_x_q;
      dv_q[0].rem    <= '0;
      dv_q[0].word   <= tia_pkg::RadW'(s2_pqr_q);
      ar_q[0].rad    <= prod[65:12];
      ar_q[0].rem    <= '0;
      ar_q[0].root   <= '0;
    end
  end

  for (genvar k = 1; k <= NDiv; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_tri_q[k] <= dv_tri_q[k-1];
        dv_x_q[k]   <= dv_x_q[k-1];
        dv_q[k]     <= tia_pkg::div_step(dv_q[k-1], {dv_x_q[k-1], 2'b00});
      end
    end

    if (k <= NSq) begin : g_root
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ar_q[k] <= tia_pkg::sqrt_step(ar_q[k-1]);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ar_q[k] <= ar_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      in_vld_q[0] <= dv_vld_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_tri_q[0]  <= dv_tri_q[NDiv];
      in_x_q[0]    <= dv_x_q[NDiv];
      in_area_q[0] <= ar_q[NDiv].root;
      in_q[0].rad  <= dv_q[NDiv].word;
      in_q[0].rem  <= '0;
      in_q[0].root <= '0;
    end
  end

  for (genvar k = 1; k <= NSq; k++) begin : g_inr
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        in_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        in_vld_q[k] <= in_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        in_tri_q[k]  <= in_tri_q[k-1];
        in_x_q[k]    <= in_x_q[k-1];
        in_area_q[k] <= in_area_q[k-1];
        in_q[k]      <= tia_pkg::sqrt_step(in_q[k-1]);
      end
    end
  end

  assign tail_vld_o    = in_vld_q[NSq];
  assign tail_o.is_tri = in_tri_q[NSq];
  assign tail_o.x      = in_x_q[NSq];
  assign tail_o.area   = in_area_q[NSq];
  assign tail_o.inr    = in_q[NSq].root[tia_pkg::InrW-1:0];

endmodule

/* src/triangle_area_inradius_core.sv */
// Triangle area and inradius core (Heron's formula, fixed point).
//
// Input channel: in_valid_i with side_a_i, side_b_i and side_c_i (12.4 unsigned).
// An item is taken at a rising edge where in_valid_i is high and in_stall_o is
// low. Output channel: out_valid_o with is_triangle_o, half_perimeter_o (x.5),
// area_o and inradius_o (x.4, truncated); taken when out_stall_i is low.
// Every item yields exactly one result item, in order. A set of sides that
// fails a strict triangle inequality gives is_triangle_o low and zero fields.
// The front end classifies the sides and computes the semi-perimeter terms in
// the cycle of acceptance and writes them into a four-entry queue. The back
// end is a pipeline: two multiply stages, a 54-stage restoring divider (one
// quotient bit per stage) with the area square root running beside it, and a
// 27-stage square root for the inradius (one root bit per stage).
// From acceptance an item passes the queue, the back pipeline and the output
// register; throughput is one item per cycle while out_stall_i holds no result.
// While out_stall_i holds a result, the whole back pipeline freezes; the
// queue keeps accepting until it is full, then in_stall_o rises.
// Reset clears the queue and all stage valid flags; no results are pending.
module triangle_area_inradius_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tia_pkg::SideW-1:0]  side_a_i,
  input  logic [tia_pkg::SideW-1:0]  side_b_i,
  input  logic [tia_pkg::SideW-1:0]  side_c_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_triangle_o,
  output logic [tia_pkg::HalfW-1:0]  half_perimeter_o,
  output logic [tia_pkg::AreaW-1:0]  area_o,
  output logic [tia_pkg::InrW-1:0]   inradius_o
);

  tia_pkg::tia_item_t   front_item, head_item;
  tia_pkg::tia_result_t tail;
  logic                 q_full, head_vld, tail_vld, adv;

  logic                       out_vld_q;
  logic                       out_tri_q;
  logic [tia_pkg::HalfW-1:0]  out_half_q;
  logic [tia_pkg::AreaW-1:0]  out_area_q;
  logic [tia_pkg::InrW-1:0]   out_inr_q;

  // The back pipeline moves whenever the output register is free or drains.
  assign adv = !out_vld_q || !out_stall_i;

  tia_front u_front (
    .side_a_i (side_a_i),
    .side_b_i (side_b_i),
    .side_c_i (side_c_i),
    .item_o   (front_item)
  );

  tia_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .item_i     (front_item),
    .full_o     (q_full),
    .pop_i      (adv),
    .head_vld_o (head_vld),
    .head_o     (head_item)
  );

  tia_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .head_vld_i (head_vld),
    .head_i     (head_item),
    .tail_vld_o (tail_vld),
    .tail_o     (tail)
  );

  assign in_stall_o = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= tail_vld;
    end
  end

  // Results of a non-triangle are forced to zero here.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tri_q  <= tail.is_tri;
      out_half_q <= tail.is_tri ? tail.x : '0;
      out_area_q <= tail.is_tri ? tail.area : '0;
      out_inr_q  <= tail.is_tri ? tail.inr : '0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign is_triangle_o    = out_tri_q;
  assign half_perimeter_o = out_half_q;
  assign area_o           = out_area_q;
  assign inradius_o       = out_inr_q;

`ifndef ASSERT_OFF
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_triangle_o) |->
      (half_perimeter_o == '0 && area_o == '0 && inradius_o == '0))
    else $error("non-triangle result carries nonzero fields");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> head_vld)
    else $error("queue reports full without a head item");

  a_tri_has_perimeter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_triangle_o) |-> (half_perimeter_o != '0))
    else $error("triangle result with zero semi-perimeter");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;

  // Clock, reset and the two channels of the core.
  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [tia_pkg::SideW-1:0] side_a_i;
  logic [tia_pkg::SideW-1:0] side_b_i;
  logic [tia_pkg::SideW-1:0] side_c_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      is_triangle_o;
  logic [tia_pkg::HalfW-1:0] half_perimeter_o;
  logic [tia_pkg::AreaW-1:0] area_o;
  logic [tia_pkg::InrW-1:0]  inradius_o;

  // Idling phases: the sender and receiver percentages are picked from these.
  typedef enum int {PhNone, PhSender, PhReceiver, PhBoth} idle_phase_e;

  typedef struct packed {
    logic                      is_tri;
    logic [tia_pkg::HalfW-1:0] x;
    logic [tia_pkg::AreaW-1:0] area;
    logic [tia_pkg::InrW-1:0]  inr;
  } tri_result_t;

  // A directed stimulus row: sides, plus an optional typed-in result.
  typedef struct {
    logic [tia_pkg::SideW-1:0] a;
    logic [tia_pkg::SideW-1:0] b;
    logic [tia_pkg::SideW-1:0] c;
    bit                        typed;
    tri_result_t               res;
  } side_row_t;

  tri_result_t  pending_results[$];
  int           errors;
  int           idle_cycles;
  int           sender_idle_pct;
  int           receiver_stall_pct;
  bit           hold_receiver;
  bit           stim_done;

  localparam int Latency     = 86;
  localparam int WatchdogMax = 20000;

  triangle_area_inradius_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .side_a_i         (side_a_i),
    .side_b_i         (side_b_i),
    .side_c_i         (side_c_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_triangle_o    (is_triangle_o),
    .half_perimeter_o (half_perimeter_o),
    .area_o           (area_o),
    .inradius_o       (inradius_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Integer square root, floor, by the bitwise method.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Heron's formula on raw 12.4 sides. The raw sum is the semi-perimeter
  // with five fraction bits; the 128-bit product keeps x*p*q*r exact.
  function automatic tri_result_t heron_result(logic [tia_pkg::SideW-1:0] a,
                                                logic [tia_pkg::SideW-1:0] b,
                                                logic [tia_pkg::SideW-1:0] c);
    tri_result_t  r;
    logic [63:0]  sx, sp, sq, sr;
    logic [127:0] full;
    logic [63:0]  pqr;
    r  = '0;
    if (({1'b0, a} + b > c) && ({1'b0, a} + c > b) && ({1'b0, b} + c > a)) begin
      sx       = 64'(a) + 64'(b) + 64'(c);
      sp       = sx - 2 * 64'(a);
      sq       = sx - 2 * 64'(b);
      sr       = sx - 2 * 64'(c);
      full     = 128'(sx * sp) * 128'(sq * sr);
      pqr      = sp * sq * sr;
      r.is_tri = 1'b1;
      r.x      = tia_pkg::HalfW'(sx);
      r.area   = tia_pkg::AreaW'(floor_sqrt(64'(full >> 12)));
      r.inr    = tia_pkg::InrW'(floor_sqrt(pqr / (4 * sx)));
    end
    return r;
  endfunction

  // Offer one item at the falling edge and hold it until it is accepted.
  // Valid stays high from one item to the next when no idle gap is drawn.
  task automatic offer_sides(logic [tia_pkg::SideW-1:0] a, logic [tia_pkg::SideW-1:0] b,
                             logic [tia_pkg::SideW-1:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    side_a_i   <= a;
    side_b_i   <= b;
    side_c_i   <= c;
    pending_results.push_back(heron_result(a, b, c));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [tia_pkg::SideW-1:0] rand_side();
    case ($urandom_range(5))
      0:       return tia_pkg::SideW'($urandom_range(65535));
      1:       return tia_pkg::SideW'($urandom_range(40));
      2:       return tia_pkg::SideW'($urandom_range(65535, 65000));
      default: return tia_pkg::SideW'($urandom_range(4000, 1));
    endcase
  endfunction

  // Mostly real triangles with random shape; the rest plain noise or
  // degenerate sets where one side equals the sum of the others.
  task automatic random_item();
    logic [tia_pkg::SideW-1:0] a, b, c;
    int                        lo, hi;
    a = rand_side();
    b = rand_side();
    case ($urandom_range(9))
      0, 1: c = rand_side();
      2: c = tia_pkg::SideW'({1'b0, a} + b);
      3: c = (a > b) ? a - b : b - a;
      default: begin
        lo = (a > b) ? a - b + 1 : b - a + 1;
        hi = int'(a) + int'(b) - 1;
        if (hi > 65535) hi = 65535;
        c = (hi >= lo) ? tia_pkg::SideW'($urandom_range(hi, lo)) : tia_pkg::SideW'($urandom);
      end
    endcase
    case ($urandom_range(2))
      0:       offer_sides(a, b, c);
      1:       offer_sides(c, a, b);
      default: offer_sides(b, c, a);
    endcase
  endtask

  // Result checking at the rising edge, against the oldest expectation.
  always @(posedge clk_i) begin
    tri_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result is_triangle=%0b half=%0d area=%0d inr=%0d",
                 $time, is_triangle_o, half_perimeter_o, area_o, inradius_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (is_triangle_o !== want.is_tri) begin
          $display("%0t: is_triangle expected %0b actual %0b", $time, want.is_tri,
                   is_triangle_o);
          errors++;
        end
        if (half_perimeter_o !== want.x) begin
          $display("%0t: half_perimeter expected %0d actual %0d", $time, want.x,
                   half_perimeter_o);
          errors++;
        end
        if (area_o !== want.area) begin
          $display("%0t: area expected %0d actual %0d", $time, want.area, area_o);
          errors++;
        end
        if (inradius_o !== want.inr) begin
          $display("%0t: inradius expected %0d actual %0d", $time, want.inr, inradius_o);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random, or holds off completely when asked to.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_receiver) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // A long receiver hold-off, counted here in cycles, while items keep coming.
  // It starts inside the first random phase, where the sender never idles.
  initial begin
    int n;
    hold_receiver = 1'b0;
    wait (stim_done == 1'b0 && rst_ni);
    repeat (250) @(negedge clk_i);
    hold_receiver = 1'b1;
    for (n = 0; n < 400; n++) @(negedge clk_i);
    hold_receiver = 1'b0;
  end

  // Watchdog: cycles in which nothing moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_receiver) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogMax) begin
      $display("triangle_area_inradius_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    side_row_t rows[$];
    side_row_t row;
    int        i, ph;
    errors = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    side_a_i = '0;
    side_b_i = '0;
    side_c_i = '0;
    out_stall_i = 1'b0;

    // Directed rows. Invalid sets and the 3-4-5 triangle in two orders are typed in.
    rows.push_back('{16'd0, 16'd0, 16'd0, 1, '0});
    rows.push_back('{16'd0, 16'd16, 16'd16, 1, '0});
    rows.push_back('{16'd16, 16'd16, 16'd32, 1, '0});
    rows.push_back('{16'd32, 16'd16, 16'd16, 1, '0});
    rows.push_back('{16'd16, 16'd48, 16'd16, 1, '0});
    rows.push_back('{16'hFFFF, 16'd0, 16'd0, 1, '0});
    rows.push_back('{16'hFFFF, 16'd1, 16'hFFFF, 0, '0});
    rows.push_back('{16'd1, 16'd1, 16'd1, 0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 16'd1, 0, '0});
    // 3-4-5: semi-perimeter 6, area 6, inradius 1.
    rows.push_back('{16'd48, 16'd64, 16'd80, 1, '{1'b1, 18'd192, 27'd96, 15'd16}});
    rows.push_back('{16'd80, 16'd48, 16'd64, 1, '{1'b1, 18'd192, 27'd96, 15'd16}});
    rows.push_back('{16'hAAAA, 16'h5555, 16'h7FFF, 0, '0});
    rows.push_back('{16'h5555, 16'hAAAA, 16'h8000, 0, '0});
    rows.push_back('{16'h8000, 16'h8000, 16'h0001, 0, '0});
    rows.push_back('{16'd2, 16'd1, 16'd1, 1, '0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < rows.size(); i++) begin
      row = rows[i];
      offer_sides(row.a, row.b, row.c);
      if (row.typed) pending_results[pending_results.size()-1] = row.res;
    end
    go_quiet();

    // Random items through the idling phases, then a run with no idling.
    for (ph = 0; ph < 5; ph++) begin
      case (idle_phase_e'(ph % 4))
        PhNone:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        PhSender:   begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
        PhReceiver: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
        default:    begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
      endcase
      for (i = 0; i < 350; i++) random_item();
      // The sender pauses here until every expected result has come.
      go_quiet();
    end

    stim_done = 1'b1;
    repeat (Latency + 20) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("triangle_area_inradius_core test passed");
    end else begin
      $display("triangle_area_inradius_core test failed");
    end
    $finish;
  end

endmodule
